### rtl/core/bla_pkg.sv
// Shared types, constants and elaboration-time ROM functions for the
// Beer-Lambert RGB attenuator. No dependencies.
package bla_pkg;

  // Channel count and field widths
  localparam int NUM_CH   = 3;
  localparam int CHAN_W   = 16;
  localparam int TRANS_W  = 17;   // Q1.16 transmittance, 0..65536
  localparam int CFG_IDX_W = 3;

  // log2(e) in Q1.16
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [NUM_CH-1:0][CHAN_W-1:0]  rgb_t;
  typedef logic [NUM_CH-1:0][TRANS_W-1:0] trans_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ABSORB_EN = 3'd0,
    CFG_COEF_RED  = 3'd1,
    CFG_COEF_GRN  = 3'd2,
    CFG_COEF_BLU  = 3'd3,
    CFG_DENSITY   = 3'd4
  } cfg_idx_t;

  // Per-stage load enables of the five-stage datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // Largest 32-bit r with r^depth (Q0.32, truncating steps) >= 0.5
  function automatic logic [31:0] exp_root(input int depth);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    lo = 64'd0;
    hi = 64'h0000_0000_FFFF_FFFF;
    for (int s = 0; s < 34; s++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        p = 64'h0000_0001_0000_0000;
        for (int i = 0; i < depth; i++) begin
          p = (p * mid) >> 32;
        end
        if (p >= 64'h0000_0000_8000_0000) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo[31:0];
  endfunction

  // Table entry k: root^k in Q0.32, rounded to Q1.16
  function automatic logic [TRANS_W-1:0] exp_entry(input logic [31:0] root, input int k);
    logic [63:0] p;
    logic [63:0] p_rnd;
    p = 64'h0000_0001_0000_0000;
    for (int i = 0; i < k; i++) begin
      p = (p * {32'd0, root}) >> 32;
    end
    p_rnd = p + 64'd32768;
    return p_rnd[32:16];
  endfunction

endpackage

### rtl/core/bla_depth.sv
// Optical depth stages: coef * density, then times path length.
// Depends on bla_pkg.
module bla_depth (
  input  logic                  clk,
  input  bla_pkg::stage_en_t    en,
  input  bla_pkg::rgb_t         coef,
  input  bla_pkg::chan_t        density,
  input  bla_pkg::chan_t        path_length,
  output logic [2:0]            ovf,     // depth >= 2^32 (Q24.24)
  output logic [2:0][23:0]      depth_q  // depth bits [31:8]
);

  logic [2:0][31:0] cd_r;
  logic [15:0]      path_r;
  logic [2:0]       ovf_r;
  logic [2:0][23:0] dq_r;
  logic [2:0][47:0] depth_full;

  // Stage 1: coefficient times density
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int c = 0; c < bla_pkg::NUM_CH; c++) begin
        cd_r[c] <= 32'(coef[c]) * 32'(density);
      end
      path_r <= path_length;
    end
  end

  // Stage 2: times path, keep an overflow flag and the useful bits
  always_comb begin
    for (int c = 0; c < bla_pkg::NUM_CH; c++) begin
      depth_full[c] = 48'(cd_r[c]) * 48'(path_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int c = 0; c < bla_pkg::NUM_CH; c++) begin
        ovf_r[c] <= |depth_full[c][47:32];
        dq_r[c]  <= depth_full[c][31:8];
      end
    end
  end

  assign ovf     = ovf_r;
  assign depth_q = dq_r;

endmodule

### rtl/core/bla_exp.sv
// Transmittance stages: 2^(-depth*log2e) from a fraction ROM and a shift.
// Depends on bla_pkg.
module bla_exp #(
  parameter int EXP_TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  bla_pkg::stage_en_t  en,
  input  logic [2:0]          ovf,
  input  logic [2:0][23:0]    depth_q,
  output bla_pkg::trans_t     trans
);

  localparam int KW = $clog2(EXP_TABLE_DEPTH);
  localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_C = DW'(EXP_TABLE_DEPTH);
  localparam logic [31:0] ROOT = bla_pkg::exp_root(EXP_TABLE_DEPTH);

  logic [bla_pkg::TRANS_W-1:0] rom [EXP_TABLE_DEPTH];

  logic [2:0][40:0]     x_full;
  logic [2:0]           sat_r;
  logic [2:0][3:0]      n_r;
  logic [2:0][15:0]     f_r;
  logic [2:0][16+DW-1:0] k_full;
  bla_pkg::trans_t      trans_r;

  // Constant table of 2^(-k/D), built at elaboration
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = bla_pkg::exp_entry(ROOT, k);
  end

  // Stage 3: scale by log2(e), split into shift and fraction
  always_comb begin
    for (int c = 0; c < bla_pkg::NUM_CH; c++) begin
      x_full[c] = 41'(depth_q[c]) * 41'(bla_pkg::LOG2E_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int c = 0; c < bla_pkg::NUM_CH; c++) begin
        sat_r[c] <= ovf[c] | (|x_full[c][40:36]);
        n_r[c]   <= x_full[c][35:32];
        f_r[c]   <= x_full[c][31:16];
      end
    end
  end

  // Stage 4: table index, lookup, shift; saturate deep paths to zero
  always_comb begin
    for (int c = 0; c < bla_pkg::NUM_CH; c++) begin
      k_full[c] = (16+DW)'(f_r[c]) * (16+DW)'(DEPTH_C);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int c = 0; c < bla_pkg::NUM_CH; c++) begin
        trans_r[c] <= sat_r[c] ? '0 : (rom[k_full[c][16 +: KW]] >> n_r[c]);
      end
    end
  end

  assign trans = trans_r;

endmodule

### rtl/core/bla_scale.sv
// Output stage: channel times transmittance, or pass-through when disabled.
// Depends on bla_pkg.
module bla_scale (
  input  logic                clk,
  input  bla_pkg::stage_en_t  en,
  input  logic                absorb_enable,
  input  bla_pkg::rgb_t       color,
  input  bla_pkg::trans_t     trans,
  output bla_pkg::rgb_t       color_out
);

  logic [2:0][32:0]  prod;
  bla_pkg::rgb_t     out_r;

  always_comb begin
    for (int c = 0; c < bla_pkg::NUM_CH; c++) begin
      prod[c] = 33'(color[c]) * 33'(trans[c]);
    end
  end

  // Stage 5: Q8.8 * Q1.16 back to Q8.8
  always_ff @(posedge clk) begin
    if (en.s5) begin
      for (int c = 0; c < bla_pkg::NUM_CH; c++) begin
        out_r[c] <= absorb_enable ? prod[c][31:16] : color[c];
      end
    end
  end

  assign color_out = out_r;

endmodule

### rtl/core/beer_lambert_rgb_attenuator.sv
// Top level of the Beer-Lambert RGB attenuator: config registers, stage
// valids and color delay line. Depends on bla_pkg, bla_depth, bla_exp, bla_scale.
//
//  channel   direction  handshake                  payload
//  in_       slave      in_tvalid / in_tready      red, green, blue, path_length
//  out_      master     out_tvalid / out_tready    red, green, blue
//  cfg_      slave      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Five register stages; one pixel per clock sustained while out_tready is high.
// Each stage holds a valid bit and loads when it is empty or the next one
// loads, so bubbles close up while the output is stalled.
// Synchronous active-low reset clears valids and coefs; absorb on, density 256.
// cfg_ready is always high; writes to unknown indexes are dropped.
module beer_lambert_rgb_attenuator #(
  parameter int EXP_TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // red_in, green_in, blue_in, path_length
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // red_out, green_out, blue_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic           absorb_en_r;
  bla_pkg::rgb_t  coef_r;
  bla_pkg::chan_t density_r;

  logic [4:0]     valid_r;      // stages 1..5
  logic [4:0]     stg_ready;
  bla_pkg::stage_en_t en;

  bla_pkg::rgb_t  color_r [4];  // color alongside stages 1..4
  bla_pkg::rgb_t  in_color;
  bla_pkg::rgb_t  color_out;

  logic [2:0]       ovf;
  logic [2:0][23:0] depth_q;
  bla_pkg::trans_t  trans;

  // Config write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      absorb_en_r <= 1'b1;
      coef_r      <= '0;
      density_r   <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (bla_pkg::cfg_idx_t'(cfg_index))
        bla_pkg::CFG_ABSORB_EN: absorb_en_r <= cfg_data[0];
        bla_pkg::CFG_COEF_RED:  coef_r[0]   <= cfg_data;
        bla_pkg::CFG_COEF_GRN:  coef_r[1]   <= cfg_data;
        bla_pkg::CFG_COEF_BLU:  coef_r[2]   <= cfg_data;
        bla_pkg::CFG_DENSITY:   density_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    stg_ready[4] = !valid_r[4] || out_tready;
    for (int s = 3; s >= 0; s--) begin
      stg_ready[s] = !valid_r[s] || stg_ready[s+1];
    end
  end

  assign en.s1 = stg_ready[0];
  assign en.s2 = stg_ready[1];
  assign en.s3 = stg_ready[2];
  assign en.s4 = stg_ready[3];
  assign en.s5 = stg_ready[4];

  assign in_tready  = stg_ready[0];
  assign out_tvalid = valid_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stg_ready[0]) valid_r[0] <= in_tvalid;
      for (int s = 1; s < 5; s++) begin
        if (stg_ready[s]) valid_r[s] <= valid_r[s-1];
      end
    end
  end

  // Color delay line
  assign in_color[0] = in_tdata[15:0];
  assign in_color[1] = in_tdata[31:16];
  assign in_color[2] = in_tdata[47:32];

  always_ff @(posedge clk) begin
    if (stg_ready[0]) color_r[0] <= in_color;
    for (int s = 1; s < 4; s++) begin
      if (stg_ready[s]) color_r[s] <= color_r[s-1];
    end
  end

  bla_depth u_depth (
    .clk         (clk),
    .en          (en),
    .coef        (coef_r),
    .density     (density_r),
    .path_length (in_tdata[63:48]),
    .ovf         (ovf),
    .depth_q     (depth_q)
  );

  bla_exp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk     (clk),
    .en      (en),
    .ovf     (ovf),
    .depth_q (depth_q),
    .trans   (trans)
  );

  bla_scale u_scale (
    .clk           (clk),
    .en            (en),
    .absorb_enable (absorb_en_r),
    .color         (color_r[3]),
    .trans         (trans),
    .color_out     (color_out)
  );

  assign out_tdata = {color_out[2], color_out[1], color_out[0]};

endmodule

### rtl/core/bla_checker.sv
// Port-level checks for the attenuator, bound to the top level.
// Depends on beer_lambert_rgb_attenuator ports only.
module bla_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Empty output stage means the whole pipeline can take a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with empty output stage");

  // Downstream ready propagates to the input side
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while out_tready high");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

endmodule

bind beer_lambert_rgb_attenuator bla_checker u_bla_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
